FILE: sv/c8alu_pkg.sv
package c8alu_pkg;

  localparam logic [4:0] OP_AND = 5'd0;
  localparam logic [4:0] OP_EOR = 5'd1;
  localparam logic [4:0] OP_ORA = 5'd2;
  localparam logic [4:0] OP_BIT = 5'd3;
  localparam logic [4:0] OP_ADC = 5'd4;
  localparam logic [4:0] OP_SBC = 5'd5;
  localparam logic [4:0] OP_CMP = 5'd6;
  localparam logic [4:0] OP_CPX = 5'd7;
  localparam logic [4:0] OP_CPY = 5'd8;
  localparam logic [4:0] OP_INC = 5'd9;
  localparam logic [4:0] OP_DEC = 5'd10;
  localparam logic [4:0] OP_INX = 5'd11;
  localparam logic [4:0] OP_INY = 5'd12;
  localparam logic [4:0] OP_DEX = 5'd13;
  localparam logic [4:0] OP_DEY = 5'd14;
  localparam logic [4:0] OP_ASL = 5'd15;
  localparam logic [4:0] OP_LSR = 5'd16;
  localparam logic [4:0] OP_ROL = 5'd17;
  localparam logic [4:0] OP_ROR = 5'd18;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_D = 3;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] m;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic       to_acc;
  } in_t;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] m;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic       to_acc;
    logic [7:0] res;
    logic       carry;
    logic       bin_v;
    logic       bit_n;
    logic       bit_v;
    logic [4:0] lo_add;
    logic [4:0] lo_sub;
  } s1_t;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic       to_acc;
    logic [7:0] res;
    logic       carry;
    logic       bin_v;
    logic       bit_n;
    logic       bit_v;
    logic [8:0] hi_add;
    logic       dec_v;
    logic [7:0] dec_sub;
  } s2_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] status;
    logic [7:0] mem;
    logic       mem_wr;
  } out_t;

endpackage

FILE: sv/c8alu_prep.sv
module c8alu_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  c8alu_pkg::in_t   in_word,
  output logic             in_ready,
  output logic             out_valid,
  output c8alu_pkg::s1_t   out_word,
  input  logic             out_ready
);

  c8alu_pkg::s1_t word_next;
  logic           c;
  logic [7:0]     mm;
  logic [8:0]     bin;
  logic [7:0]     bin_r;
  logic [7:0]     src;
  logic [7:0]     cmp_reg;
  logic [8:0]     diff;
  logic [4:0]     lo_a;
  logic [5:0]     lo_s;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    c       = in_word.p[c8alu_pkg::FLAG_C];
    mm      = (in_word.op == c8alu_pkg::OP_SBC) ? ~in_word.m : in_word.m;
    bin     = {1'b0, in_word.a} + {1'b0, mm} + {8'b0, c};
    bin_r   = bin[7:0];
    src     = in_word.to_acc ? in_word.a : in_word.m;
    cmp_reg = in_word.a;
    if (in_word.op == c8alu_pkg::OP_CPX) begin
      cmp_reg = in_word.x;
    end else if (in_word.op == c8alu_pkg::OP_CPY) begin
      cmp_reg = in_word.y;
    end
    diff = {1'b0, cmp_reg} - {1'b0, in_word.m};
    lo_a = {1'b0, in_word.a[3:0]} + {1'b0, in_word.m[3:0]} + {4'b0, c};
    lo_s = {2'b0, in_word.a[3:0]} - {2'b0, in_word.m[3:0]} + {5'b0, c} - 6'd1;

    word_next        = '0;
    word_next.op     = in_word.op;
    word_next.m      = in_word.m;
    word_next.a      = in_word.a;
    word_next.x      = in_word.x;
    word_next.y      = in_word.y;
    word_next.p      = in_word.p;
    word_next.to_acc = in_word.to_acc;
    word_next.bin_v  = ((in_word.a ^ bin_r) & (mm ^ bin_r) & 8'h80) != 8'h00;
    word_next.bit_n  = in_word.m[7];
    word_next.bit_v  = in_word.m[6];
    word_next.lo_add = (lo_a >= 5'd10) ? {1'b1, lo_a[3:0] + 4'd6} : lo_a;
    word_next.lo_sub = lo_s[5] ? {1'b1, lo_s[3:0] - 4'd6} : lo_s[4:0];

    unique case (in_word.op) inside
      c8alu_pkg::OP_AND: word_next.res = in_word.a & in_word.m;
      c8alu_pkg::OP_EOR: word_next.res = in_word.a ^ in_word.m;
      c8alu_pkg::OP_ORA: word_next.res = in_word.a | in_word.m;
      c8alu_pkg::OP_BIT: word_next.res = in_word.a & in_word.m;
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        word_next.res   = bin_r;
        word_next.carry = bin[8];
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        word_next.res   = diff[7:0];
        word_next.carry = !diff[8];
      end
      c8alu_pkg::OP_INC: word_next.res = in_word.m + 8'd1;
      c8alu_pkg::OP_DEC: word_next.res = in_word.m - 8'd1;
      c8alu_pkg::OP_INX: word_next.res = in_word.x + 8'd1;
      c8alu_pkg::OP_INY: word_next.res = in_word.y + 8'd1;
      c8alu_pkg::OP_DEX: word_next.res = in_word.x - 8'd1;
      c8alu_pkg::OP_DEY: word_next.res = in_word.y - 8'd1;
      c8alu_pkg::OP_ASL: begin
        word_next.res   = {src[6:0], 1'b0};
        word_next.carry = src[7];
      end
      c8alu_pkg::OP_LSR: begin
        word_next.res   = {1'b0, src[7:1]};
        word_next.carry = src[0];
      end
      c8alu_pkg::OP_ROL: begin
        word_next.res   = {src[6:0], c};
        word_next.carry = src[7];
      end
      c8alu_pkg::OP_ROR: begin
        word_next.res   = {c, src[7:1]};
        word_next.carry = src[0];
      end
      default: word_next.res = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

FILE: sv/c8alu_decadj.sv
module c8alu_decadj (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  c8alu_pkg::s1_t   in_word,
  output logic             in_ready,
  output logic             out_valid,
  output c8alu_pkg::s2_t   out_word,
  input  logic             out_ready
);

  c8alu_pkg::s2_t word_next;
  logic [9:0]     sv;
  logic [9:0]     full;
  logic [9:0]     full_adj;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sv = {{2{in_word.a[7]}}, in_word.a[7:4], 4'b0}
       + {{2{in_word.m[7]}}, in_word.m[7:4], 4'b0}
       + {5'b0, in_word.lo_add};
    full = {2'b0, in_word.a[7:4], 4'b0}
         - {2'b0, in_word.m[7:4], 4'b0}
         + {{5{in_word.lo_sub[4]}}, in_word.lo_sub};
    full_adj = full[9] ? (full - 10'h060) : full;

    word_next.op      = in_word.op;
    word_next.a       = in_word.a;
    word_next.x       = in_word.x;
    word_next.y       = in_word.y;
    word_next.p       = in_word.p;
    word_next.to_acc  = in_word.to_acc;
    word_next.res     = in_word.res;
    word_next.carry   = in_word.carry;
    word_next.bin_v   = in_word.bin_v;
    word_next.bit_n   = in_word.bit_n;
    word_next.bit_v   = in_word.bit_v;
    word_next.hi_add  = {1'b0, in_word.a[7:4], 4'b0} + {1'b0, in_word.m[7:4], 4'b0}
                      + {4'b0, in_word.lo_add};
    word_next.dec_v   = !((sv[9:7] == 3'b000) || (sv[9:7] == 3'b111));
    word_next.dec_sub = full_adj[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

FILE: sv/c8alu_flags.sv
module c8alu_flags (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  c8alu_pkg::s2_t   in_word,
  output logic             in_ready,
  output logic             out_valid,
  output c8alu_pkg::out_t  out_word,
  input  logic             out_ready
);

  c8alu_pkg::out_t word_next;
  logic [9:0]      hi_adj;
  logic            dec;

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[c8alu_pkg::FLAG_Z] = (v == 8'h00);
    r[c8alu_pkg::FLAG_N] = v[7];
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dec    = in_word.p[c8alu_pkg::FLAG_D];
    hi_adj = {1'b0, in_word.hi_add}
           + ((in_word.hi_add >= 9'h0a0) ? 10'h060 : 10'h000);

    word_next.acc    = in_word.a;
    word_next.x      = in_word.x;
    word_next.y      = in_word.y;
    word_next.status = in_word.p;
    word_next.mem    = 8'h00;
    word_next.mem_wr = 1'b0;

    unique case (in_word.op) inside
      c8alu_pkg::OP_AND, c8alu_pkg::OP_EOR, c8alu_pkg::OP_ORA: begin
        word_next.acc    = in_word.res;
        word_next.status = with_nz(in_word.p, in_word.res);
      end
      c8alu_pkg::OP_BIT: begin
        word_next.status[c8alu_pkg::FLAG_Z] = (in_word.res == 8'h00);
        word_next.status[c8alu_pkg::FLAG_N] = in_word.bit_n;
        word_next.status[c8alu_pkg::FLAG_V] = in_word.bit_v;
      end
      c8alu_pkg::OP_ADC: begin
        if (dec) begin
          word_next.acc                       = hi_adj[7:0];
          word_next.status[c8alu_pkg::FLAG_N] = in_word.hi_add[7];
          word_next.status[c8alu_pkg::FLAG_V] = in_word.dec_v;
          word_next.status[c8alu_pkg::FLAG_Z] = (in_word.res == 8'h00);
          word_next.status[c8alu_pkg::FLAG_C] = (hi_adj[9:8] != 2'b00);
        end else begin
          word_next.acc                       = in_word.res;
          word_next.status                    = with_nz(in_word.p, in_word.res);
          word_next.status[c8alu_pkg::FLAG_C] = in_word.carry;
          word_next.status[c8alu_pkg::FLAG_V] = in_word.bin_v;
        end
      end
      c8alu_pkg::OP_SBC: begin
        word_next.acc                       = dec ? in_word.dec_sub : in_word.res;
        word_next.status                    = with_nz(in_word.p, in_word.res);
        word_next.status[c8alu_pkg::FLAG_C] = in_word.carry;
        word_next.status[c8alu_pkg::FLAG_V] = in_word.bin_v;
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        word_next.status                    = with_nz(in_word.p, in_word.res);
        word_next.status[c8alu_pkg::FLAG_C] = in_word.carry;
      end
      c8alu_pkg::OP_INC, c8alu_pkg::OP_DEC: begin
        word_next.mem    = in_word.res;
        word_next.mem_wr = 1'b1;
        word_next.status = with_nz(in_word.p, in_word.res);
      end
      c8alu_pkg::OP_INX, c8alu_pkg::OP_DEX: begin
        word_next.x      = in_word.res;
        word_next.status = with_nz(in_word.p, in_word.res);
      end
      c8alu_pkg::OP_INY, c8alu_pkg::OP_DEY: begin
        word_next.y      = in_word.res;
        word_next.status = with_nz(in_word.p, in_word.res);
      end
      c8alu_pkg::OP_ASL, c8alu_pkg::OP_LSR, c8alu_pkg::OP_ROL, c8alu_pkg::OP_ROR: begin
        word_next.status                    = with_nz(in_word.p, in_word.res);
        word_next.status[c8alu_pkg::FLAG_C] = in_word.carry;
        if (in_word.to_acc) begin
          word_next.acc = in_word.res;
        end else begin
          word_next.mem    = in_word.res;
          word_next.mem_wr = 1'b1;
        end
      end
      default: begin
        word_next.mem_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_word <= word_next;
    end
  end

`ifndef SYNTHESIS
  a_mid_bits_pass: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(in_valid && in_ready)) |->
      (out_word.status[5:2] == $past(in_word.p[5:2])))
    else $error("status bits D and unused changed");
`endif

endmodule

FILE: sv/cpu8_alu_flags.sv
// Three register stages: prepare, decimal adjust, flag merge and output.
// Each accepted word passes the prepare, decimal adjust and flag merge registers in order.
// Throughput: one word per cycle; a stall holds each full stage in place.
// Reset clears the stage valid bits only; data registers are not reset.
// in_stall is low whenever out_stall is low.
module cpu8_alu_flags (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] operation,
  input  logic [7:0] operand,
  input  logic [7:0] acc_in,
  input  logic [7:0] x_in,
  input  logic [7:0] y_in,
  input  logic [7:0] status_in,
  input  logic       on_accumulator,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] acc_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] status_out,
  output logic [7:0] mem_out,
  output logic       mem_write
);

  c8alu_pkg::in_t  in_word;
  c8alu_pkg::s1_t  s1_word;
  c8alu_pkg::s2_t  s2_word;
  c8alu_pkg::out_t out_word;
  logic            rdy1;
  logic            rdy2;
  logic            rdy3;
  logic            v1;
  logic            v2;

  assign in_word.op     = operation;
  assign in_word.m      = operand;
  assign in_word.a      = acc_in;
  assign in_word.x      = x_in;
  assign in_word.y      = y_in;
  assign in_word.p      = status_in;
  assign in_word.to_acc = on_accumulator;

  assign in_stall = !rdy1;

  c8alu_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_ready  (rdy1),
    .out_valid (v1),
    .out_word  (s1_word),
    .out_ready (rdy2)
  );

  c8alu_decadj u_decadj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_word   (s1_word),
    .in_ready  (rdy2),
    .out_valid (v2),
    .out_word  (s2_word),
    .out_ready (rdy3)
  );

  c8alu_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_word   (s2_word),
    .in_ready  (rdy3),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_ready (!out_stall)
  );

  assign acc_out    = out_word.acc;
  assign x_out      = out_word.x;
  assign y_out      = out_word.y;
  assign status_out = out_word.status;
  assign mem_out    = out_word.mem;
  assign mem_write  = out_word.mem_wr;

`ifndef SYNTHESIS
  a_no_stall_through: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_mem_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mem_write) |-> (mem_out == 8'h00))
    else $error("mem_out nonzero without write");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v1 && v2))
    else $error("input stalled with an empty stage");
`endif

endmodule

FILE: tb/cpu8_alu_flags_tb.sv
`timescale 1ns / 1ps

module cpu8_alu_flags_tb;

  localparam logic [4:0] OP_FIRST_UNUSED = 5'd19;
  localparam logic [4:0] OP_LAST_UNUSED = 5'd31;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_MIX = 610;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {FLOW_SLOW_SINK, FLOW_SLOW_SOURCE, FLOW_FULL} flow_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [4:0] operation;
  logic [7:0] operand;
  logic [7:0] acc_in;
  logic [7:0] x_in;
  logic [7:0] y_in;
  logic [7:0] status_in;
  logic       on_accumulator;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] status_out;
  logic [7:0] mem_out;
  logic       mem_write;

  flow_t            flow = FLOW_SLOW_SINK;
  c8alu_pkg::out_t  pending_results[$];
  c8alu_pkg::in_t   dir_words[$];
  bit               dir_typed[$];
  c8alu_pkg::out_t  dir_want[$];
  c8alu_pkg::out_t  oldest;
  int    mismatches = 0;
  int    results_checked = 0;
  int    words_sent = 0;
  int    cycles = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;

  cpu8_alu_flags dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .operand(operand),
    .acc_in(acc_in),
    .x_in(x_in),
    .y_in(y_in),
    .status_in(status_in),
    .on_accumulator(on_accumulator),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .acc_out(acc_out),
    .x_out(x_out),
    .y_out(y_out),
    .status_out(status_out),
    .mem_out(mem_out),
    .mem_write(mem_write)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] v);
    st[c8alu_pkg::FLAG_Z] = (v == 8'h00);
    st[c8alu_pkg::FLAG_N] = v[7];
    return st;
  endfunction

  function automatic logic [7:0] compare_flags(input logic [7:0] st, input logic [7:0] r,
                                               input logic [7:0] m);
    st = set_nz(st, r - m);
    st[c8alu_pkg::FLAG_C] = (r >= m);
    return st;
  endfunction

  function automatic c8alu_pkg::out_t alu_predict(input c8alu_pkg::in_t w);
    c8alu_pkg::out_t r;
    logic [7:0] a, x, y, p, v, sh, nm, res;
    logic [8:0] bin;
    logic       cin, cout;
    int         lo, hi, sv, full;
    a = w.a;
    x = w.x;
    y = w.y;
    p = w.p;
    cin = w.p[c8alu_pkg::FLAG_C];
    r = '0;
    unique case (w.op) inside
      c8alu_pkg::OP_ASL, c8alu_pkg::OP_LSR, c8alu_pkg::OP_ROL, c8alu_pkg::OP_ROR: begin
        v = w.to_acc ? a : w.m;
        case (w.op)
          c8alu_pkg::OP_ASL: {cout, sh} = {v, 1'b0};
          c8alu_pkg::OP_LSR: {sh, cout} = {1'b0, v};
          c8alu_pkg::OP_ROL: {cout, sh} = {v, cin};
          default: {sh, cout} = {cin, v};
        endcase
        p = set_nz(p, sh);
        p[c8alu_pkg::FLAG_C] = cout;
        if (w.to_acc) begin
          a = sh;
        end else begin
          r.mem = sh;
          r.mem_wr = 1'b1;
        end
      end
      c8alu_pkg::OP_AND: begin
        a = a & w.m;
        p = set_nz(p, a);
      end
      c8alu_pkg::OP_EOR: begin
        a = a ^ w.m;
        p = set_nz(p, a);
      end
      c8alu_pkg::OP_ORA: begin
        a = a | w.m;
        p = set_nz(p, a);
      end
      c8alu_pkg::OP_BIT: begin
        p[c8alu_pkg::FLAG_Z] = ((a & w.m) == 8'h00);
        p[c8alu_pkg::FLAG_N] = w.m[7];
        p[c8alu_pkg::FLAG_V] = w.m[6];
      end
      c8alu_pkg::OP_ADC: begin
        bin = a + w.m + cin;
        if (!p[c8alu_pkg::FLAG_D]) begin
          res = bin[7:0];
          p = set_nz(p, res);
          p[c8alu_pkg::FLAG_C] = bin[8];
          p[c8alu_pkg::FLAG_V] = (a[7] ~^ w.m[7]) & (a[7] ^ res[7]);
          a = res;
        end else begin
          lo = int'(a[3:0]) + int'(w.m[3:0]) + int'(cin);
          if (lo >= 10) lo = ((lo + 6) & 15) + 16;
          sv = int'($signed({a[7:4], 4'h0})) + int'($signed({w.m[7:4], 4'h0})) + lo;
          hi = int'({a[7:4], 4'h0}) + int'({w.m[7:4], 4'h0}) + lo;
          p[c8alu_pkg::FLAG_N] = hi[7];
          p[c8alu_pkg::FLAG_V] = (sv < -128) || (sv > 127);
          p[c8alu_pkg::FLAG_Z] = (bin[7:0] == 8'h00);
          if (hi >= 'ha0) hi += 'h60;
          p[c8alu_pkg::FLAG_C] = (hi >= 'h100);
          a = hi[7:0];
        end
      end
      c8alu_pkg::OP_SBC: begin
        nm = ~w.m;
        bin = a + nm + cin;
        res = bin[7:0];
        p = set_nz(p, res);
        p[c8alu_pkg::FLAG_C] = bin[8];
        p[c8alu_pkg::FLAG_V] = (a[7] ~^ nm[7]) & (a[7] ^ res[7]);
        if (p[c8alu_pkg::FLAG_D]) begin
          lo = int'(a[3:0]) - int'(w.m[3:0]) + int'(cin) - 1;
          if (lo < 0) lo = ((lo - 6) & 15) - 16;
          full = int'({a[7:4], 4'h0}) - int'({w.m[7:4], 4'h0}) + lo;
          if (full < 0) full -= 'h60;
          res = full[7:0];
        end
        a = res;
      end
      c8alu_pkg::OP_CMP: p = compare_flags(p, a, w.m);
      c8alu_pkg::OP_CPX: p = compare_flags(p, x, w.m);
      c8alu_pkg::OP_CPY: p = compare_flags(p, y, w.m);
      c8alu_pkg::OP_INC: begin
        r.mem = w.m + 8'd1;
        r.mem_wr = 1'b1;
        p = set_nz(p, r.mem);
      end
      c8alu_pkg::OP_DEC: begin
        r.mem = w.m - 8'd1;
        r.mem_wr = 1'b1;
        p = set_nz(p, r.mem);
      end
      c8alu_pkg::OP_INX: begin
        x = x + 8'd1;
        p = set_nz(p, x);
      end
      c8alu_pkg::OP_INY: begin
        y = y + 8'd1;
        p = set_nz(p, y);
      end
      c8alu_pkg::OP_DEX: begin
        x = x - 8'd1;
        p = set_nz(p, x);
      end
      c8alu_pkg::OP_DEY: begin
        y = y - 8'd1;
        p = set_nz(p, y);
      end
      default: begin
      end
    endcase
    r.acc = a;
    r.x = x;
    r.y = y;
    r.status = p;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic c8alu_pkg::in_t random_word();
    c8alu_pkg::in_t w;
    if ($urandom_range(0, 9) == 0) begin
      w.op = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else begin
      w.op = 5'($urandom_range(c8alu_pkg::OP_AND, c8alu_pkg::OP_ROR));
    end
    w.m = pick_byte();
    w.a = pick_byte();
    w.x = pick_byte();
    w.y = pick_byte();
    w.p = 8'($urandom);
    w.to_acc = 1'($urandom);
    // bias arithmetic toward valid BCD in decimal mode
    if ((w.op == c8alu_pkg::OP_ADC || w.op == c8alu_pkg::OP_SBC)
        && $urandom_range(0, 1) == 1) begin
      w.a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      w.m = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      w.p[c8alu_pkg::FLAG_D] = 1'b1;
    end
    return w;
  endfunction

  task automatic add_row(input c8alu_pkg::in_t w, input bit typed,
                         input c8alu_pkg::out_t want);
    dir_words.push_back(w);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  task automatic offer(input c8alu_pkg::in_t w, input c8alu_pkg::out_t want);
    int gap;
    gap = (flow == FLOW_SLOW_SINK) ? 20 : (flow == FLOW_SLOW_SOURCE) ? 51 : 0;
    while ($urandom_range(0, 99) < gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = w.op;
    operand = w.m;
    acc_in = w.a;
    x_in = w.x;
    y_in = w.y;
    status_in = w.p;
    on_accumulator = w.to_acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(want);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic run_random(input flow_t f, input int count);
    c8alu_pkg::in_t w;
    flow = f;
    repeat (count) begin
      w = random_word();
      offer(w, alu_predict(w));
    end
  endtask

  task automatic check_byte(input string what, input logic [7:0] exp_v,
                            input logic [7:0] got);
    if (got !== exp_v) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, exp_v, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (flow == FLOW_FULL && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (flow)
        FLOW_SLOW_SINK: out_stall = ($urandom_range(0, 99) < 51);
        FLOW_SLOW_SOURCE: out_stall = ($urandom_range(0, 99) < 20);
        default: out_stall = 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no word outstanding, acc %02h status %02h",
                 $time, acc_out, status_out);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_byte("acc_out", oldest.acc, acc_out);
        check_byte("x_out", oldest.x, x_out);
        check_byte("y_out", oldest.y, y_out);
        check_byte("status_out", oldest.status, status_out);
        check_byte("mem_out", oldest.mem, mem_out);
        check_byte("mem_write", {7'b0, oldest.mem_wr}, {7'b0, mem_write});
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = c8alu_pkg::OP_AND;
    operand = 8'h00;
    acc_in = 8'h00;
    x_in = 8'h00;
    y_in = 8'h00;
    status_in = 8'h00;
    on_accumulator = 1'b0;

    // word: op, operand, A, X, Y, P, on_accumulator
    // result: A, X, Y, P, mem, mem_write
    add_row({c8alu_pkg::OP_AND, 8'h00, 8'hff, 8'h12, 8'h34, 8'h00, 1'b0}, 1'b1,
            {8'h00, 8'h12, 8'h34, 8'h02, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_ORA, 8'h80, 8'h00, 8'hff, 8'h00, 8'h00, 1'b1}, 1'b1,
            {8'h80, 8'hff, 8'h00, 8'h80, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_EOR, 8'hff, 8'hff, 8'h00, 8'hff, 8'h82, 1'b0}, 1'b1,
            {8'h00, 8'h00, 8'hff, 8'h02, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_BIT, 8'hc0, 8'h3f, 8'h01, 8'h02, 8'h00, 1'b0}, 1'b1,
            {8'h3f, 8'h01, 8'h02, 8'hc2, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_ADC, 8'h01, 8'h7f, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
            {8'h80, 8'h00, 8'h00, 8'hc0, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_ADC, 8'h01, 8'hff, 8'h00, 8'h00, 8'h40, 1'b0}, 1'b1,
            {8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0}, 1'b1,
            {8'hff, 8'h00, 8'h00, 8'h80, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_ADC, 8'h01, 8'h99, 8'h00, 8'h00, 8'h08, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_ADC, 8'h46, 8'h58, 8'h00, 8'h00, 8'h09, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_ADC, 8'hff, 8'hff, 8'h00, 8'h00, 8'h09, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 8'h09, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_SBC, 8'haa, 8'hff, 8'h00, 8'h00, 8'h08, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_CMP, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
            {8'h10, 8'h00, 8'h00, 8'h03, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_CPX, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
            {8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_CPY, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0}, 1'b1,
            {8'h00, 8'h00, 8'hff, 8'h81, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_INC, 8'hff, 8'h11, 8'h22, 8'h33, 8'h00, 1'b1}, 1'b1,
            {8'h11, 8'h22, 8'h33, 8'h02, 8'h00, 1'b1});
    add_row({c8alu_pkg::OP_DEC, 8'h00, 8'h11, 8'h22, 8'h33, 8'h02, 1'b0}, 1'b1,
            {8'h11, 8'h22, 8'h33, 8'h80, 8'hff, 1'b1});
    add_row({c8alu_pkg::OP_INX, 8'h00, 8'h00, 8'hff, 8'h00, 8'h80, 1'b0}, 1'b1,
            {8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_INY, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h00, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_DEX, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_DEY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_ASL, 8'h55, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
            {8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 1'b0});
    add_row({c8alu_pkg::OP_LSR, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_ROL, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0}, 1'b0, '0);
    add_row({c8alu_pkg::OP_ROR, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 1'b1}, 1'b0, '0);
    add_row({OP_LAST_UNUSED, 8'haa, 8'h55, 8'h01, 8'hfe, 8'hcb, 1'b1}, 1'b1,
            {8'h55, 8'h01, 8'hfe, 8'hcb, 8'h00, 1'b0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    flow = FLOW_SLOW_SINK;
    for (i = 0; i < dir_words.size(); i++) begin
      offer(dir_words[i], dir_typed[i] ? dir_want[i] : alu_predict(dir_words[i]));
    end
    run_random(FLOW_SLOW_SINK, RANDOM_PER_MIX);
    run_random(FLOW_SLOW_SOURCE, RANDOM_PER_MIX);
    run_random(FLOW_FULL, RANDOM_PER_MIX);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words (%0d directed), %0d results checked: all 19 operations,",
             words_sent, dir_words.size(), results_checked);
    $display("binary and decimal arithmetic, unused codes, three flow mixes, one long hold");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/c8alu_pkg.sv
sv/c8alu_prep.sv
sv/c8alu_decadj.sv
sv/c8alu_flags.sv
sv/cpu8_alu_flags.sv
tb/cpu8_alu_flags_tb.sv
